// ----- src/hsvrgb_pkg.sv -----
// ---------------------------------------------------------------------------
// hsvrgb_pkg
// Widths and constants for the hsv to rgb converter pipeline.
// ---------------------------------------------------------------------------
package hsvrgb_pkg;

  localparam int HUE_W = 9;
  localparam int PCT_W = 7;
  localparam int CH_W  = 8;
  localparam int K_W   = 13;   // channel weight 0..6000
  localparam int N_W   = 20;   // channel numerator 0..600000
  localparam int A_W   = 18;   // numerator*17/64, 0..159375
  localparam int NCH   = 3;    // red, green, blue

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 24;

  localparam logic [HUE_W-1:0] HUE_WRAP  = 9'd360;
  localparam logic [PCT_W-1:0] PCT_WRAP  = 7'd101;
  localparam logic [K_W-1:0]   K_FULL    = 13'd6000;
  localparam logic [5:0]       SECTOR    = 6'd60;

  // floor(a/625) ~= (a * RECIP) >> RECIP_SH, at most one low, fixed by one compare
  localparam logic [A_W-1:0]   RECIP     = 18'd214748;
  localparam int               RECIP_SH  = 27;
  localparam logic [9:0]       DIV_LO    = 10'd625;

  // sector of the hue, 60 degrees each
  localparam logic [2:0] SEC_RY = 3'd0;
  localparam logic [2:0] SEC_YG = 3'd1;
  localparam logic [2:0] SEC_GC = 3'd2;
  localparam logic [2:0] SEC_CB = 3'd3;
  localparam logic [2:0] SEC_BM = 3'd4;
  localparam logic [2:0] SEC_MR = 3'd5;

  localparam int CH_R = 0;
  localparam int CH_G = 1;
  localparam int CH_B = 2;

  typedef logic [K_W-1:0] k_t;
  typedef logic [N_W-1:0] num_t;
  typedef logic [A_W-1:0] a_t;
  typedef logic [CH_W-1:0] ch_t;

endpackage

// ----- src/hsv_to_rgb_converter_unit.sv -----
// Converts one hsv color per beat to 8-bit rgb. Hue wraps modulo 360, saturation
// and brightness wrap modulo 101 and are read as percent. The pipeline is six
// register stages deep (range reduction, sector weights, numerator multiply,
// scale by 17/64, reciprocal multiply, remainder correction), and one beat can
// enter on every clock while the output is not stalled. A stall on the output
// side holds the whole pipeline in place.
// ---------------------------------------------------------------------------
// hsv_to_rgb_converter_unit
// Six-stage fixed point hsv to rgb conversion, one beat per clock unless the output stalls.
// ---------------------------------------------------------------------------
module hsv_to_rgb_converter_unit (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // [8:0] hue, [15:9] saturation, [22:16] brightness, [23] zero
  input  logic [hsvrgb_pkg::IN_DATA_W-1:0]      in_tdata,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // [7:0] red, [15:8] green, [23:16] blue
  output logic [hsvrgb_pkg::OUT_DATA_W-1:0]     out_tdata
);

  localparam int NSTG = 6;

  logic            en;
  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] vld_nxt;

  assign en        = !vld_r[NSTG-1] || out_tready;
  assign in_tready = en;
  assign vld_nxt   = {vld_r[NSTG-2:0], in_tvalid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  // stage 1: range reduction
  logic [hsvrgb_pkg::HUE_W-1:0] hue_in, h_nxt, h_r;
  logic [hsvrgb_pkg::PCT_W-1:0] sat_in, bri_in, s_nxt, s_r, v_nxt, v_r;

  assign hue_in = in_tdata[8:0];
  assign sat_in = in_tdata[15:9];
  assign bri_in = in_tdata[22:16];

  assign h_nxt = (hue_in >= hsvrgb_pkg::HUE_WRAP) ? hue_in - hsvrgb_pkg::HUE_WRAP : hue_in;
  assign s_nxt = (sat_in >= hsvrgb_pkg::PCT_WRAP) ? sat_in - hsvrgb_pkg::PCT_WRAP : sat_in;
  assign v_nxt = (bri_in >= hsvrgb_pkg::PCT_WRAP) ? bri_in - hsvrgb_pkg::PCT_WRAP : bri_in;

  always_ff @(posedge clk) begin
    if (en) begin
      h_r <= h_nxt;
      s_r <= s_nxt;
      v_r <= v_nxt;
    end
  end

  // stage 2: sector and per-channel weight (numerator / v)
  logic [2:0]                   sec;
  logic [hsvrgb_pkg::HUE_W-1:0] pair_base;
  logic [6:0]                   t;
  logic [5:0]                   d;
  logic [12:0]                  sd, s60;
  hsvrgb_pkg::k_t               kx, kz;
  hsvrgb_pkg::k_t               k_nxt [hsvrgb_pkg::NCH];
  hsvrgb_pkg::k_t               k_r   [hsvrgb_pkg::NCH];
  logic [hsvrgb_pkg::PCT_W-1:0] v2_r;

  always_comb begin
    if (h_r < 9'd60)       sec = hsvrgb_pkg::SEC_RY;
    else if (h_r < 9'd120) sec = hsvrgb_pkg::SEC_YG;
    else if (h_r < 9'd180) sec = hsvrgb_pkg::SEC_GC;
    else if (h_r < 9'd240) sec = hsvrgb_pkg::SEC_CB;
    else if (h_r < 9'd300) sec = hsvrgb_pkg::SEC_BM;
    else                   sec = hsvrgb_pkg::SEC_MR;
  end

  // h mod 120 from the sector pair
  always_comb begin
    case (sec[2:1])
      2'd0:    pair_base = 9'd0;
      2'd1:    pair_base = 9'd120;
      default: pair_base = 9'd240;
    endcase
  end

  assign t   = 7'(h_r - pair_base);
  assign d   = (t >= 7'(hsvrgb_pkg::SECTOR)) ? 6'(t - 7'(hsvrgb_pkg::SECTOR))
                                             : 6'(7'(hsvrgb_pkg::SECTOR) - t);
  assign sd  = 13'(s_r) * 13'(d);
  assign s60 = 13'(s_r) * 13'd60;
  assign kx  = hsvrgb_pkg::K_FULL - sd;
  assign kz  = hsvrgb_pkg::K_FULL - s60;

  always_comb begin
    unique case (sec)
      hsvrgb_pkg::SEC_RY: begin
        k_nxt[hsvrgb_pkg::CH_R] = hsvrgb_pkg::K_FULL;
        k_nxt[hsvrgb_pkg::CH_G] = kx;
        k_nxt[hsvrgb_pkg::CH_B] = kz;
      end
      hsvrgb_pkg::SEC_YG: begin
        k_nxt[hsvrgb_pkg::CH_R] = kx;
        k_nxt[hsvrgb_pkg::CH_G] = hsvrgb_pkg::K_FULL;
        k_nxt[hsvrgb_pkg::CH_B] = kz;
      end
      hsvrgb_pkg::SEC_GC: begin
        k_nxt[hsvrgb_pkg::CH_R] = kz;
        k_nxt[hsvrgb_pkg::CH_G] = hsvrgb_pkg::K_FULL;
        k_nxt[hsvrgb_pkg::CH_B] = kx;
      end
      hsvrgb_pkg::SEC_CB: begin
        k_nxt[hsvrgb_pkg::CH_R] = kz;
        k_nxt[hsvrgb_pkg::CH_G] = kx;
        k_nxt[hsvrgb_pkg::CH_B] = hsvrgb_pkg::K_FULL;
      end
      hsvrgb_pkg::SEC_BM: begin
        k_nxt[hsvrgb_pkg::CH_R] = kx;
        k_nxt[hsvrgb_pkg::CH_G] = kz;
        k_nxt[hsvrgb_pkg::CH_B] = hsvrgb_pkg::K_FULL;
      end
      default: begin
        k_nxt[hsvrgb_pkg::CH_R] = hsvrgb_pkg::K_FULL;
        k_nxt[hsvrgb_pkg::CH_G] = kz;
        k_nxt[hsvrgb_pkg::CH_B] = kx;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      k_r  <= k_nxt;
      v2_r <= v_r;
    end
  end

  // stages 3..6: per-channel lanes
  hsvrgb_pkg::num_t n_nxt  [hsvrgb_pkg::NCH];
  hsvrgb_pkg::num_t n_r    [hsvrgb_pkg::NCH];
  hsvrgb_pkg::a_t   a_nxt  [hsvrgb_pkg::NCH];
  hsvrgb_pkg::a_t   a_r    [hsvrgb_pkg::NCH];
  hsvrgb_pkg::a_t   a5_r   [hsvrgb_pkg::NCH];
  logic [35:0]      prod   [hsvrgb_pkg::NCH];
  hsvrgb_pkg::ch_t  q0_nxt [hsvrgb_pkg::NCH];
  hsvrgb_pkg::ch_t  q0_r   [hsvrgb_pkg::NCH];
  hsvrgb_pkg::a_t   qm     [hsvrgb_pkg::NCH];
  hsvrgb_pkg::a_t   rem    [hsvrgb_pkg::NCH];
  hsvrgb_pkg::ch_t  q_nxt  [hsvrgb_pkg::NCH];
  hsvrgb_pkg::ch_t  q_r    [hsvrgb_pkg::NCH];
  logic [23:0]      n17    [hsvrgb_pkg::NCH];

  always_comb begin
    for (int i = 0; i < hsvrgb_pkg::NCH; i++) begin
      n_nxt[i]  = hsvrgb_pkg::N_W'(k_r[i]) * hsvrgb_pkg::N_W'(v2_r);
      // 255/600000 = 17/40000 = (17/64)/625
      n17[i]    = {n_r[i], 4'b0000} + 24'(n_r[i]);
      a_nxt[i]  = n17[i][23:6];
      prod[i]   = 36'(a_r[i]) * 36'(hsvrgb_pkg::RECIP);
      q0_nxt[i] = prod[i][hsvrgb_pkg::RECIP_SH +: hsvrgb_pkg::CH_W];
      qm[i]     = hsvrgb_pkg::A_W'(q0_r[i]) * hsvrgb_pkg::A_W'(hsvrgb_pkg::DIV_LO);
      rem[i]    = a5_r[i] - qm[i];
      q_nxt[i]  = (rem[i] >= hsvrgb_pkg::A_W'(hsvrgb_pkg::DIV_LO)) ? q0_r[i] + 8'd1 : q0_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_r  <= n_nxt;
      a_r  <= a_nxt;
      q0_r <= q0_nxt;
      a5_r <= a_r;
      q_r  <= q_nxt;
    end
  end

  assign out_tvalid = vld_r[NSTG-1];
  assign out_tdata  = {q_r[hsvrgb_pkg::CH_B], q_r[hsvrgb_pkg::CH_G], q_r[hsvrgb_pkg::CH_R]};

endmodule
